// ===== rtl/lsvm_pkg.sv =====
`default_nettype none
package lsvm_pkg;

  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_START = 3'd1,
    ACT_FSTOP = 3'd2,
    ACT_RSTOP = 3'd3,
    ACT_WRITE = 3'd4
  } action_e;

  typedef struct packed {
    logic [2:0]         action;
    logic [3:0]         voice_slot;
    logic [15:0]        start_addr;
    logic [15:0]        sound_length;
    logic               loop_enable;
    logic [15:0]        loop_end;
    logic [15:0]        loop_start;
    logic signed [15:0] sample_word;
    logic [15:0]        volume_word;
    logic               set_volume;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] mixed_sample;
    logic [4:0]         voices_active;
  } out_item_t;

  // Per-voice record held in the voice memory.
  typedef struct packed {
    logic        loopable;
    logic [15:0] start;
    logic [15:0] length;
    logic [15:0] loop_end;
    logic [15:0] loop_start;
    logic [15:0] position;
  } voice_t;

  localparam logic [15:0] VolumeUnity = 16'd32768;

endpackage
`default_nettype wire

// ===== rtl/looping_sample_voice_mixer.sv =====
`default_nettype none
// Multi-voice looping sample player. Commands (start, force stop, sample
// write, volume set) each take one beat; a request stop also holds off the
// input while the voice record comes out of memory and the flags update. A
// tick walks the voice slots one at a time through the voice record memory
// and the sample memory, both synchronous with registered reads: every slot
// passes through a voice read, a sample read, and an accumulate and write
// back step; then a multiply and a rounding step scale the saturated sum by
// the master volume and a last step hands the beat to the result register,
// waiting there while the result register is still full with the previous
// beat. The active and looping flags live in flip-flops cleared by reset;
// voice records and sample memory are undefined until written. One result
// beat per tick, none for other commands.
module looping_sample_voice_mixer #(
  parameter int NUM_VOICES       = 16,
  parameter int SAMPLE_ADDR_BITS = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire lsvm_pkg::in_item_t    in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output lsvm_pkg::out_item_t        out_data_o
);
  import lsvm_pkg::*;

  localparam int VB = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int AB = SAMPLE_ADDR_BITS;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_VRD   = 3'd1;  // voice record read issued
  localparam logic [2:0] S_SRD   = 3'd2;  // sample read issued
  localparam logic [2:0] S_ACC   = 3'd3;  // accumulate, write back
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_RND   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [NUM_VOICES-1:0] active_q, looping_q;
  logic [15:0] volume_q;
  logic [VB-1:0] vidx_q;
  logic signed [20:0] sum_q;
  logic [5:0] count_q;
  logic signed [33:0] prod_q;
  logic signed [15:0] mix_q;
  out_item_t res_q;
  logic res_valid_q;

  voice_t vmem [NUM_VOICES];
  logic signed [15:0] smem [2**AB];
  voice_t vrd_q;
  logic signed [15:0] srd_q;

  // Voice memory port: start writes a new record, tick writes the position.
  logic   vwe;
  logic [VB-1:0] vwa;
  voice_t vwd;
  logic [AB-1:0] sraddr;

  // Request stop: in the cycle after the request is taken, the record is out of memory.
  logic rstop_q;
  logic [VB-1:0] rslot_q;

  in_item_t in;
  assign in = in_data_i;
  logic slot_ok;
  assign slot_ok = ({2'b0, in.voice_slot} < 6'(NUM_VOICES));
  logic [VB-1:0] slot;
  assign slot = VB'(in.voice_slot);

  // Hold off input during a tick and while a request stop resolves.
  assign in_ready_o = (state_q == S_IDLE) && !rstop_q;
  logic acc;
  assign acc = in_valid_i && in_ready_o;

  // Position step for the voice being visited.
  logic [16:0] pos_n;
  logic [16:0] pos_l;
  logic done_v;
  always_comb begin
    pos_n = {1'b0, vrd_q.position} + 17'd1;
    pos_l = (looping_q[vidx_q] && pos_n == {1'b0, vrd_q.loop_end})
            ? {1'b0, vrd_q.loop_start} : pos_n;
    done_v = (pos_l >= {1'b0, vrd_q.length});
  end

  assign sraddr = AB'({1'b0, vrd_q.start} + {1'b0, vrd_q.position});

  always_comb begin
    vwe = 1'b0;
    vwa = vidx_q;
    vwd = vrd_q;
    if (acc && in.action == ACT_START && slot_ok && !active_q[slot]) begin
      vwe = 1'b1;
      vwa = slot;
      vwd = '{loopable: in.loop_enable, start: in.start_addr,
              length: in.sound_length, loop_end: in.loop_end,
              loop_start: in.loop_start, position: 16'd0};
    end else if (state_q == S_ACC && active_q[vidx_q] && !done_v) begin
      vwe = 1'b1;
      vwd.position = pos_l[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vwe) vmem[vwa] <= vwd;
    vrd_q <= vmem[(state_q == S_IDLE) ? slot : vidx_q];
    if (acc && in.action == ACT_WRITE && !in.set_volume)
      smem[AB'(in.start_addr)] <= in.sample_word;
    srd_q <= smem[sraddr];
  end

  // Saturate sum, rounded product.
  logic signed [15:0] sat_sum;
  assign sat_sum = (sum_q > 21'sd32767) ? 16'sh7fff :
                   (sum_q < -21'sd32768) ? 16'sh8000 : sum_q[15:0];
  logic signed [34:0] rnd;
  assign rnd = (35'(prod_q) + 35'sd16384) >>> 15;
  logic signed [15:0] rsat;
  assign rsat = (rnd > 35'sd32767) ? 16'sh7fff :
                (rnd < -35'sd32768) ? 16'sh8000 : rnd[15:0];

  logic res_load;
  assign res_load = (state_q == S_OUT) && (!res_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (acc && in.action == ACT_TICK) state_d = S_VRD;
      S_VRD:  state_d = S_SRD;
      S_SRD:  state_d = S_ACC;
      S_ACC:  state_d = (vidx_q == VB'(NUM_VOICES - 1)) ? S_MUL : S_VRD;
      S_MUL:  state_d = S_RND;
      S_RND:  state_d = S_OUT;
      S_OUT:  if (res_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rstop_q <= 1'b0;
    else rstop_q <= acc && in.action == ACT_RSTOP && slot_ok;
  end
  always_ff @(posedge clk_i) rslot_q <= slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= '0;
      looping_q   <= '0;
      volume_q    <= VolumeUnity;
      vidx_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (res_load) res_valid_q <= 1'b1;
      else if (out_ready_i) res_valid_q <= 1'b0;
      if (acc) begin
        case (in.action)
          ACT_TICK: vidx_q <= '0;
          ACT_START: if (slot_ok && !active_q[slot]) begin
            active_q[slot]  <= 1'b1;
            looping_q[slot] <= in.loop_enable;
          end
          ACT_FSTOP: if (slot_ok) active_q[slot] <= 1'b0;
          ACT_RSTOP: ;  // resolved after the record read, see below
          ACT_WRITE: if (in.set_volume) volume_q <= in.volume_word;
          default: ;
        endcase
      end
      if (state_q == S_ACC) begin
        if (active_q[vidx_q] && done_v) active_q[vidx_q] <= 1'b0;
        if (vidx_q != VB'(NUM_VOICES - 1)) vidx_q <= vidx_q + 1'b1;
      end
      if (rstop_q && active_q[rslot_q]) begin
        if (vrd_q.loopable) looping_q[rslot_q] <= 1'b0;
        else active_q[rslot_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && acc && in.action == ACT_TICK) begin
      sum_q <= '0;
      count_q <= '0;
    end
    if (state_q == S_ACC && active_q[vidx_q]) begin
      sum_q <= sum_q + 21'(srd_q);
      if (!done_v) count_q <= count_q + 6'd1;
    end
    if (state_q == S_MUL) prod_q <= 34'(sat_sum) * $signed({18'd0, volume_q});
    if (state_q == S_RND) mix_q <= rsat;
    // Advance the beat only once the result register is free.
    if (res_load) begin
      res_q.mixed_sample  <= mix_q;
      res_q.voices_active <= count_q[4:0];
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_data_o  = res_q;

  // Block holds off input while a tick is in flight.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o) else $error("ready during tick");
  a_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q) == S_OUT) else $error("stray result");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> {1'b0, res_q.voices_active} <= 6'(NUM_VOICES)) else $error("count");

endmodule
`default_nettype wire
